// File: rtl/core/box_plane_sphere_classify_assert.svh
// assertion macros for the box plane sphere classifier
`ifndef BOX_PLANE_SPHERE_CLASSIFY_ASSERT_SVH
`define BOX_PLANE_SPHERE_CLASSIFY_ASSERT_SVH
`ifndef SYNTH
`define BPSC_ASSERT_IMP(lbl, ck, rstn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (a) |-> (b)) \
    else $error("bpsc assertion failed");
`define BPSC_ASSERT_NXT(lbl, ck, rstn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (a) |=> (b)) \
    else $error("bpsc assertion failed");
`else
`define BPSC_ASSERT_IMP(lbl, ck, rstn, a, b)
`define BPSC_ASSERT_NXT(lbl, ck, rstn, a, b)
`endif
`endif

// File: rtl/core/bpsc_pkg.sv
// shared types and constants for the box plane sphere classifier
`timescale 1ns / 1ps
`default_nettype none
package bpsc_pkg;
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS      = 16;
  localparam int CFG_IDX_BITS   = 3;

  localparam logic OP_PLANE  = 1'b0;
  localparam logic OP_SPHERE = 1'b1;

  localparam logic [1:0] VERDICT_ZERO = 2'b00;
  localparam logic [1:0] VERDICT_POS  = 2'b01;
  localparam logic [1:0] VERDICT_NEG  = 2'b11;

  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_X   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_Y   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_Z   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS   = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOL      = 3'd7;

  typedef struct packed {
    logic valid;
    logic op;
  } ctl_t;
endpackage
`default_nettype wire

// File: rtl/core/bpsc_front.sv
// stage 1: center offsets and sphere radius sums
`timescale 1ns / 1ps
`default_nettype none
module bpsc_front #(
  parameter int W = bpsc_pkg::COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic               op,
  input  wire logic signed [W-1:0] px, py, pz,
  input  wire logic signed [W-1:0] nx, ny, nz,
  input  wire logic [W-2:0]        sr,
  input  wire logic signed [W-1:0] cx, cy, cz,
  input  wire logic [W-2:0]        rad,
  input  wire logic [W-2:0]        tol,
  output bpsc_pkg::ctl_t           ctl_r,
  output logic signed [W:0]        v_r [3],
  output logic signed [W-1:0]      n_r [3],
  output logic [W:0]               outer_r,
  output logic signed [W:0]        inner_r
);
  bpsc_pkg::ctl_t ctl_nxt;

  always_comb begin
    ctl_nxt.valid = accept;
    ctl_nxt.op    = op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r[0]  <= (W+1)'(cx) - (W+1)'(px);
    v_r[1]  <= (W+1)'(cy) - (W+1)'(py);
    v_r[2]  <= (W+1)'(cz) - (W+1)'(pz);
    n_r[0]  <= nx;
    n_r[1]  <= ny;
    n_r[2]  <= nz;
    outer_r <= (W+1)'(rad) + (W+1)'(sr) + (W+1)'(tol);
    inner_r <= $signed((W+1)'(sr)) - $signed((W+1)'(tol)) - $signed((W+1)'(rad));
  end
endmodule
`default_nettype wire

// File: rtl/core/bpsc_mul.sv
// stage 2: products for dot terms, corner offsets and squared radii
`timescale 1ns / 1ps
`default_nettype none
module bpsc_mul #(
  parameter int W = bpsc_pkg::COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bpsc_pkg::ctl_t     ctl,
  input  wire logic signed [W:0]   v [3],
  input  wire logic signed [W-1:0] n [3],
  input  wire logic signed [W-1:0] h [3],
  input  wire logic [W:0]          outer,
  input  wire logic signed [W:0]   inner,
  output bpsc_pkg::ctl_t           ctl_r,
  output logic signed [2*W+1:0]    prod_r [3],
  output logic signed [2*W-1:0]    nh_r [3],
  output logic [2*W+1:0]           osq_r,
  output logic [2*W-3:0]           isq_r,
  output logic                     ipos_r
);
  logic signed [W:0] a [3];

  // plane: n * v, sphere: v * v
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a[k] = (ctl.op == bpsc_pkg::OP_SPHERE) ? v[k] : (W+1)'(n[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod_r[k] <= a[k] * v[k];
      nh_r[k]   <= n[k] * h[k];
    end
    osq_r  <= outer * outer;
    isq_r  <= inner[W-2:0] * inner[W-2:0];
    ipos_r <= (inner > 0);
  end
endmodule
`default_nettype wire

// File: rtl/core/bpsc_accum.sv
// stages 3 and 4: center dot sum, corner offsets, corner distances
`timescale 1ns / 1ps
`default_nettype none
module bpsc_accum #(
  parameter int W  = bpsc_pkg::COORD_BITS_DEF,
  localparam int DW = 2*W+4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bpsc_pkg::ctl_t     ctl,
  input  wire logic signed [2*W+1:0] prod [3],
  input  wire logic signed [2*W-1:0] nh [3],
  input  wire logic [2*W+1:0]     osq,
  input  wire logic [2*W-3:0]     isq,
  input  wire logic               ipos,
  output bpsc_pkg::ctl_t          ctl_r,
  output logic signed [DW-1:0]    d_r,
  output logic signed [DW-1:0]    di_r [8],
  output logic [2*W+1:0]          osq_r,
  output logic [2*W-3:0]          isq_r,
  output logic                    ipos_r
);
  bpsc_pkg::ctl_t         ctl3_r;
  logic signed [DW-1:0]   d3_r;
  logic signed [DW-1:0]   q3_r [8];
  logic [2*W+1:0]         osq3_r;
  logic [2*W-3:0]         isq3_r;
  logic                   ipos3_r;
  logic signed [DW-1:0]   q_nxt [8];

  // corner bit k set selects the minus half extent on axis k
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      q_nxt[j] = '0;
      for (int k = 0; k < 3; k++) begin
        if (j[k]) begin
          q_nxt[j] = q_nxt[j] - DW'(nh[k]);
        end else begin
          q_nxt[j] = q_nxt[j] + DW'(nh[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
      ctl_r  <= '0;
    end else begin
      ctl3_r <= ctl;
      ctl_r  <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    d3_r    <= DW'(prod[0]) + DW'(prod[1]) + DW'(prod[2]);
    q3_r    <= q_nxt;
    osq3_r  <= osq;
    isq3_r  <= isq;
    ipos3_r <= ipos;
    d_r     <= d3_r;
    for (int j = 0; j < 8; j++) begin
      di_r[j] <= d3_r + q3_r[j];
    end
    osq_r   <= osq3_r;
    isq_r   <= isq3_r;
    ipos_r  <= ipos3_r;
  end
endmodule
`default_nettype wire

// File: rtl/core/bpsc_decide.sv
// stage 5: comparisons and verdict register
`timescale 1ns / 1ps
`default_nettype none
module bpsc_decide #(
  parameter int W  = bpsc_pkg::COORD_BITS_DEF,
  localparam int DW = 2*W+4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bpsc_pkg::ctl_t     ctl,
  input  wire logic signed [DW-1:0] d,
  input  wire logic signed [DW-1:0] di [8],
  input  wire logic [2*W+1:0]     osq,
  input  wire logic [2*W-3:0]     isq,
  input  wire logic               ipos,
  input  wire logic [W-2:0]       rad,
  input  wire logic [W-2:0]       tol,
  output logic                    valid_r,
  output logic [1:0]              verdict_r
);
  logic signed [DW-1:0] lim, tolw;
  logic [7:0]           in_band, above;
  logic [1:0]           verdict_nxt;

  always_comb begin
    lim  = $signed(DW'(W'(rad) + W'(tol))) <<< bpsc_pkg::FRAC_BITS;
    tolw = $signed(DW'(tol)) <<< bpsc_pkg::FRAC_BITS;
    for (int j = 0; j < 8; j++) begin
      in_band[j] = (di[j] >= -tolw) && (di[j] <= tolw);
      above[j]   = di[j] > tolw;
    end
    if (ctl.op == bpsc_pkg::OP_PLANE) begin
      if (d > lim) begin
        verdict_nxt = bpsc_pkg::VERDICT_POS;
      end else if (d < -lim) begin
        verdict_nxt = bpsc_pkg::VERDICT_NEG;
      end else if (|in_band) begin
        verdict_nxt = bpsc_pkg::VERDICT_ZERO;
      end else if (&above) begin
        verdict_nxt = bpsc_pkg::VERDICT_POS;
      end else if (above == 8'h00) begin
        verdict_nxt = bpsc_pkg::VERDICT_NEG;
      end else begin
        verdict_nxt = bpsc_pkg::VERDICT_ZERO;
      end
    end else begin
      // d holds the squared center distance for spheres
      if (d > $signed(DW'(osq))) begin
        verdict_nxt = bpsc_pkg::VERDICT_NEG;
      end else if (ipos && (d < $signed(DW'(isq)))) begin
        verdict_nxt = bpsc_pkg::VERDICT_POS;
      end else begin
        verdict_nxt = bpsc_pkg::VERDICT_ZERO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
  end
endmodule
`default_nettype wire

// File: rtl/core/box_plane_sphere_classify.sv
// top level of the box versus plane or sphere classifier
`timescale 1ns / 1ps
`default_nettype none
// channel   ports                              handshake
// input     in_op, in_point_*, in_normal_*,    start high, busy low
//           in_sphere_radius
// result    out_verdict                        out_valid, one cycle
// config    cfg_index, cfg_data                cfg_we
//
// one query enters every cycle; the verdict reaches out_verdict through the
// five register stages (offset, multiply, sum, corner add, compare)
// busy never rises: the pipeline never waits, the receiver cannot stall
// synchronous active-low reset clears stage valid bits and the box registers
`include "box_plane_sphere_classify_assert.svh"
module box_plane_sphere_classify #(
  parameter int COORD_BITS = bpsc_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_op,
  input  wire logic signed [COORD_BITS-1:0]      in_point_x,
  input  wire logic signed [COORD_BITS-1:0]      in_point_y,
  input  wire logic signed [COORD_BITS-1:0]      in_point_z,
  input  wire logic signed [COORD_BITS-1:0]      in_normal_x,
  input  wire logic signed [COORD_BITS-1:0]      in_normal_y,
  input  wire logic signed [COORD_BITS-1:0]      in_normal_z,
  input  wire logic [COORD_BITS-2:0]             in_sphere_radius,
  output logic                                   out_valid,
  output logic signed [1:0]                      out_verdict,
  input  wire logic                              cfg_we,
  input  wire logic [bpsc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [COORD_BITS-1:0]             cfg_data
);
  localparam int W  = COORD_BITS;
  localparam int DW = 2*W+4;

  // box registers
  logic signed [W-1:0] center_r [3];
  logic signed [W-1:0] half_r [3];
  logic [W-2:0]        radius_r;
  logic [W-2:0]        tol_r;

  logic accept;

  // stage wires
  bpsc_pkg::ctl_t       ctl1, ctl2, ctl4;
  logic signed [W:0]    v1 [3];
  logic signed [W-1:0]  n1 [3];
  logic [W:0]           outer1;
  logic signed [W:0]    inner1;
  logic signed [2*W+1:0] prod2 [3];
  logic signed [2*W-1:0] nh2 [3];
  logic [2*W+1:0]       osq2, osq4;
  logic [2*W-3:0]       isq2, isq4;
  logic                 ipos2, ipos4;
  logic signed [DW-1:0] d4;
  logic signed [DW-1:0] di4 [8];
  logic [1:0]           verdict;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        center_r[k] <= '0;
        half_r[k]   <= '0;
      end
      radius_r <= '0;
      tol_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpsc_pkg::REG_CENTER_X: center_r[0] <= cfg_data;
        bpsc_pkg::REG_CENTER_Y: center_r[1] <= cfg_data;
        bpsc_pkg::REG_CENTER_Z: center_r[2] <= cfg_data;
        bpsc_pkg::REG_HALF_X:   half_r[0]   <= cfg_data;
        bpsc_pkg::REG_HALF_Y:   half_r[1]   <= cfg_data;
        bpsc_pkg::REG_HALF_Z:   half_r[2]   <= cfg_data;
        bpsc_pkg::REG_RADIUS:   radius_r    <= cfg_data[W-2:0];
        bpsc_pkg::REG_TOL:      tol_r       <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // stage 1: offsets c - p and radius sums
  bpsc_front #(.W(W)) u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept), .op(in_op),
    .px(in_point_x), .py(in_point_y), .pz(in_point_z),
    .nx(in_normal_x), .ny(in_normal_y), .nz(in_normal_z),
    .sr(in_sphere_radius),
    .cx(center_r[0]), .cy(center_r[1]), .cz(center_r[2]),
    .rad(radius_r), .tol(tol_r),
    .ctl_r(ctl1), .v_r(v1), .n_r(n1), .outer_r(outer1), .inner_r(inner1)
  );

  // stage 2: all multiplications in parallel
  bpsc_mul #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .ctl(ctl1), .v(v1), .n(n1), .h(half_r),
    .outer(outer1), .inner(inner1),
    .ctl_r(ctl2), .prod_r(prod2), .nh_r(nh2), .osq_r(osq2), .isq_r(isq2),
    .ipos_r(ipos2)
  );

  // stages 3 and 4: dot product sum and the eight corner distances
  bpsc_accum #(.W(W)) u_accum (
    .clk(clk), .rst_n(rst_n), .ctl(ctl2), .prod(prod2), .nh(nh2),
    .osq(osq2), .isq(isq2), .ipos(ipos2),
    .ctl_r(ctl4), .d_r(d4), .di_r(di4), .osq_r(osq4), .isq_r(isq4),
    .ipos_r(ipos4)
  );

  // stage 5: early-out and corner tests, registered result word
  bpsc_decide #(.W(W)) u_decide (
    .clk(clk), .rst_n(rst_n), .ctl(ctl4), .d(d4), .di(di4),
    .osq(osq4), .isq(isq4), .ipos(ipos4), .rad(radius_r), .tol(tol_r),
    .valid_r(out_valid), .verdict_r(verdict)
  );

  assign out_verdict = $signed(verdict);

  // every word moves one stage per cycle, none dropped; verdict never 2'b10
  `BPSC_ASSERT_NXT(a_s1_s2, clk, rst_n, ctl1.valid, ctl2.valid)
  `BPSC_ASSERT_NXT(a_s4_out, clk, rst_n, ctl4.valid, out_valid)
  `BPSC_ASSERT_IMP(a_verdict_code, clk, rst_n, out_valid, verdict != 2'b10)
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// testbench for the box plane sphere classifier: exact-arithmetic predictor and result checker
`timescale 1ns / 1ps
module tb;
  localparam int CB = 32;
  localparam int LATENCY = 5;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = bpsc_pkg::OP_PLANE;
  logic signed [CB-1:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic signed [CB-1:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic [CB-2:0] in_sphere_radius = '0;
  logic out_valid;
  logic signed [1:0] out_verdict;
  logic cfg_we = 1'b0;
  logic [bpsc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CB-1:0] cfg_data = '0;

  box_plane_sphere_classify #(.COORD_BITS(CB)) uut (.*);

  // box as the predictor sees it
  logic signed [CB-1:0] box_center [3];
  logic signed [CB-1:0] box_half [3];
  logic [CB-2:0] box_radius, box_tol;

  logic [1:0] verdict_q [$];
  int errors = 0;
  int n_words = 0, n_results = 0, n_plane = 0, n_sphere = 0;
  int cycles = 0;
  bit idle_on = 1'b1;

  initial forever #5 clk = ~clk;

  // cycle watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: errors");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // result checker: each strobed word pops the oldest expected verdict
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_results++;
      if (verdict_q.size() == 0) report($sformatf("unexpected verdict %0d", out_verdict));
      else begin
        logic [1:0] want;
        want = verdict_q.pop_front();
        if (out_verdict !== want)
          report($sformatf("verdict got %b want %b", out_verdict, want));
      end
    end
  end

  // plane: dot of normal with corner offset, all at 128-bit width
  function automatic logic [1:0] plane_verdict(input logic signed [CB-1:0] p [3],
                                               input logic signed [CB-1:0] n [3]);
    logic signed [127:0] d, lim, tol, acc;
    logic signed [127:0] off;
    int ref_sign, s;
    ref_sign = 0;
    d = 0;
    for (int k = 0; k < 3; k++) begin
      off = 128'(box_center[k]) - 128'(p[k]);
      d += 128'(n[k]) * off;
    end
    lim = (128'({1'b0, box_radius}) + 128'({1'b0, box_tol})) <<< 16;
    if (d > lim) return bpsc_pkg::VERDICT_POS;
    if (d < -lim) return bpsc_pkg::VERDICT_NEG;
    tol = 128'({1'b0, box_tol}) <<< 16;
    for (int c = 0; c < 8; c++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        off = 128'(box_center[k]) - 128'(p[k]);
        off = c[k] ? off - 128'(box_half[k]) : off + 128'(box_half[k]);
        acc += 128'(n[k]) * off;
      end
      if (acc >= -tol && acc <= tol) return bpsc_pkg::VERDICT_ZERO;
      s = (acc > tol) ? 1 : -1;
      if (ref_sign == 0) ref_sign = s;
      else if (ref_sign != s) return bpsc_pkg::VERDICT_ZERO;
    end
    return ref_sign > 0 ? bpsc_pkg::VERDICT_POS : bpsc_pkg::VERDICT_NEG;
  endfunction

  // sphere: compare squared center distance against squared radius sums
  function automatic logic [1:0] sphere_verdict(input logic signed [CB-1:0] p [3],
                                                input logic [CB-2:0] r);
    logic signed [127:0] dsq, off, outer, inner;
    dsq = 0;
    for (int k = 0; k < 3; k++) begin
      off = 128'(box_center[k]) - 128'(p[k]);
      dsq += off * off;
    end
    outer = 128'({1'b0, box_radius}) + 128'({1'b0, r}) + 128'({1'b0, box_tol});
    if (dsq > outer * outer) return bpsc_pkg::VERDICT_NEG;
    inner = 128'({1'b0, r}) - 128'({1'b0, box_tol}) - 128'({1'b0, box_radius});
    if (inner > 0 && dsq < inner * inner) return bpsc_pkg::VERDICT_POS;
    return bpsc_pkg::VERDICT_ZERO;
  endfunction

  // sender gap: start drops for the whole burst
  task automatic idle_burst();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // drive one query word, wait for acceptance, record the expected verdict
  // start stays high so the next word can follow at once
  task automatic send_query(input logic op, input logic signed [CB-1:0] p [3],
                            input logic signed [CB-1:0] n [3], input logic [CB-2:0] r);
    logic [1:0] want;
    in_op <= op;
    in_point_x <= p[0]; in_point_y <= p[1]; in_point_z <= p[2];
    in_normal_x <= n[0]; in_normal_y <= n[1]; in_normal_z <= n[2];
    in_sphere_radius <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    want = (op == bpsc_pkg::OP_PLANE) ? plane_verdict(p, n) : sphere_verdict(p, r);
    verdict_q = {verdict_q, want};
    if (op == bpsc_pkg::OP_PLANE) n_plane++; else n_sphere++;
    n_words++;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bpsc_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [CB-1:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      bpsc_pkg::REG_CENTER_X: box_center[0] = val;
      bpsc_pkg::REG_CENTER_Y: box_center[1] = val;
      bpsc_pkg::REG_CENTER_Z: box_center[2] = val;
      bpsc_pkg::REG_HALF_X:   box_half[0] = val;
      bpsc_pkg::REG_HALF_Y:   box_half[1] = val;
      bpsc_pkg::REG_HALF_Z:   box_half[2] = val;
      bpsc_pkg::REG_RADIUS:   box_radius = val[CB-2:0];
      bpsc_pkg::REG_TOL:      box_tol = val[CB-2:0];
      default: ;
    endcase
  endtask

  task automatic set_box(input logic signed [CB-1:0] c [3], input logic signed [CB-1:0] h [3],
                         input logic [CB-1:0] rad, input logic [CB-1:0] tol);
    write_reg(bpsc_pkg::REG_CENTER_X, c[0]);
    write_reg(bpsc_pkg::REG_CENTER_Y, c[1]);
    write_reg(bpsc_pkg::REG_CENTER_Z, c[2]);
    write_reg(bpsc_pkg::REG_HALF_X, h[0]);
    write_reg(bpsc_pkg::REG_HALF_Y, h[1]);
    write_reg(bpsc_pkg::REG_HALF_Z, h[2]);
    write_reg(bpsc_pkg::REG_RADIUS, rad);
    write_reg(bpsc_pkg::REG_TOL, tol);
  endtask

  function automatic logic signed [CB-1:0] rnd_coord(input int scale);
    case (scale)
      0: return $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
      1: return $signed($urandom_range(0, 32'h40_0000)) - 32'sh20_0000;
      default: return $urandom;
    endcase
  endfunction

  // zero box from reset, then field extremes and the special cases
  task automatic test_directed();
    logic signed [CB-1:0] p [3], n [3], c [3], h [3];
    logic signed [CB-1:0] ext [4] = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1};
    p = '{0, 0, 0}; n = '{0, 0, 0};
    send_query(bpsc_pkg::OP_PLANE, p, n, '0);                   // zero normal
    send_query(bpsc_pkg::OP_SPHERE, p, n, 31'h7fff_ffff);
    foreach (ext[i]) begin
      p = '{ext[i], ext[3-i], ext[i]};
      n = '{ext[3-i], ext[i], ext[i]};
      send_query(bpsc_pkg::OP_PLANE, p, n, '1);
      send_query(bpsc_pkg::OP_SPHERE, p, n, i[0] ? 31'h7fff_ffff : 31'd0);
    end
    drain();
    // unit box, nonunit normals and negative half extents
    c = '{32'sh1_0000, -32'sh2_0000, 0};
    h = '{-32'sh1_0000, 32'sh1_0000, 32'sh1_0000};
    set_box(c, h, 32'h1_bb67, 32'h100);
    n = '{32'sh3_0000, 0, 0};
    p = '{32'sh0_0000, 0, 0}; send_query(bpsc_pkg::OP_PLANE, p, n, '0);   // touching corner
    p = '{-32'sh5_0000, 0, 0}; send_query(bpsc_pkg::OP_PLANE, p, n, '0);  // above
    p = '{32'sh5_0000, 0, 0}; send_query(bpsc_pkg::OP_PLANE, p, n, '0);   // below
    p = '{32'sh1_8000, 0, 0}; send_query(bpsc_pkg::OP_PLANE, p, n, '0);   // straddles
    n = '{32'sh1_0000, 32'sh1_0000, 0};
    p = '{32'sh2_2000, -32'sh2_0000, 0};
    send_query(bpsc_pkg::OP_PLANE, p, n, '0);                             // inside radius
    p = c; send_query(bpsc_pkg::OP_SPHERE, p, n, 31'h10_0000);            // box inside
    send_query(bpsc_pkg::OP_SPHERE, p, n, 31'h1_0000);                    // intersects
    p = '{32'sh10_0000, 0, 0};
    send_query(bpsc_pkg::OP_SPHERE, p, n, 31'h1_0000);                    // disjoint
    drain();
    write_reg(bpsc_pkg::REG_TOL, 32'hffff_ffff);      // tolerance extreme, top bit dropped
    write_reg(bpsc_pkg::REG_RADIUS, 32'h8000_0000);
    n = '{32'sh1_0000, 0, 0};
    send_query(bpsc_pkg::OP_PLANE, p, n, '0);
    send_query(bpsc_pkg::OP_SPHERE, p, n, 31'h7fff_ffff);
    drain();
  endtask

  // random boxes, each followed by a stream of mixed queries
  task automatic test_random(input int phases, input int per_phase, input bit pauses);
    logic signed [CB-1:0] p [3], n [3], c [3], h [3];
    logic [CB-1:0] rad, tol;
    int scale;
    for (int ph = 0; ph < phases; ph++) begin
      scale = (ph % 5 == 4) ? 2 : $urandom_range(0, 1);
      foreach (c[k]) begin
        c[k] = rnd_coord(scale);
        h[k] = rnd_coord(scale) >>> 1;
      end
      rad = (scale == 2) ? $urandom : $urandom_range(0, 32'h40_0000);
      tol = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h2000);
      set_box(c, h, rad, tol);
      if ($urandom_range(0, 3) == 0) write_reg(bpsc_pkg::REG_TOL, '0);
      for (int i = 0; i < per_phase; i++) begin
        logic op;
        op = 1'($urandom_range(0, 1));
        foreach (p[k]) begin
          p[k] = (scale == 2) ? rnd_coord(2) : c[k] + (rnd_coord(scale) <<< $urandom_range(0, 1));
          n[k] = $urandom_range(0, 7) == 0 ? rnd_coord(2) : rnd_coord(0);
        end
        if ($urandom_range(0, 15) == 0) n = '{0, 0, 0};
        send_query(op, p, n, scale == 2 ? 31'($urandom) : 31'($urandom_range(0, 32'h40_0000)));
        idle_burst();
        if (pauses && i == per_phase / 2) begin
          // sender holds off until the pipe is empty
          start <= 1'b0;
          while (verdict_q.size() != 0) @(negedge clk);
        end
      end
      drain();
    end
  endtask

  initial begin
    foreach (box_center[k]) begin
      box_center[k] = 0;
      box_half[k] = 0;
    end
    box_radius = 0;
    box_tol = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(20, 30, 1'b1);
    idle_on = 1'b0;
    test_random(8, 25, 1'b0);
    drain();
    $display("covered %0d words (%0d plane, %0d sphere), %0d verdicts checked",
             n_words, n_plane, n_sphere, n_results);
    $display("boxes from zero to full-range coordinates, tolerance up to its widest value");
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      if (verdict_q.size() != 0) $display("%0d verdicts never arrived", verdict_q.size());
      $display("tb: errors");
    end
    $finish;
  end
endmodule

// File: box_plane_sphere_classify.f
+incdir+rtl/core
rtl/core/bpsc_pkg.sv
rtl/core/bpsc_front.sv
rtl/core/bpsc_mul.sv
rtl/core/bpsc_accum.sv
rtl/core/bpsc_decide.sv
rtl/core/box_plane_sphere_classify.sv
tb/sv/tb.sv
